// ----- design/point_in_triangle_mesh_test_defines.svh -----
// assertion macros used by the checker file
`ifndef POINT_IN_TRIANGLE_MESH_TEST_DEFINES_SVH
`define POINT_IN_TRIANGLE_MESH_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pit assertion failed");

// next-cycle implication, disabled during reset
`define PIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pit assertion failed");

`endif

// ----- design/pit_pkg.sv -----
// ----------------------------------------------------------------------------
// pit_pkg
// shared constants, codes and types of the point-in-triangle mesh test
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;
  localparam int CFG_W             = 9;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // corner codes
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  // token that travels with each triangle through the pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

endpackage

// ----- design/pit_ram.sv -----
// ----------------------------------------------------------------------------
// pit_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pit_wmul.sv -----
// ----------------------------------------------------------------------------
// pit_wmul
// two-stage exact signed multiplier built from four half-width products
// ----------------------------------------------------------------------------
module pit_wmul #(
  parameter int W = 36
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int HI = W - H;
  localparam int WW = 2 * W;

  logic [H-1:0]          al, bl;
  logic signed [HI-1:0]  ah, bh;
  logic [2*H-1:0]        pll;
  logic signed [H+HI:0]  plh, phl;
  logic signed [2*HI-1:0] phh;

  // split each operand into unsigned low and signed high halves
  assign al = a[H-1:0];
  assign bl = b[H-1:0];
  assign ah = a[W-1:H];
  assign bh = b[W-1:H];

  // partial products
  always_ff @(posedge clk) begin
    pll <= al * bl;
    plh <= signed'({1'b0, al}) * bh;
    phl <= ah * signed'({1'b0, bl});
    phh <= ah * bh;
  end

  // recombine
  always_ff @(posedge clk) begin
    p <= (WW'(phh) << (2 * H)) + (WW'(plh) << H) + (WW'(phl) << H) + WW'(pll);
  end

endmodule

// ----- design/pit_tri_test.sv -----
// ----------------------------------------------------------------------------
// pit_tri_test
// pipelined barycentric test of one triangle per cycle against a point
// ----------------------------------------------------------------------------
module pit_tri_test import pit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tok_t                    tok_in,
  input  logic [3*COORD_BITS-1:0] a_in,
  input  logic [3*COORD_BITS-1:0] b_in,
  input  logic [3*COORD_BITS-1:0] c_in,
  input  logic [3*COORD_BITS-1:0] p_in,
  output tok_t                    tok_out,
  output logic                    hit
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int WW   = 2 * DOTW;

  tok_t s2_tok, s3_tok, s4_tok, s5_tok, s6_tok, s7_tok, s8_tok;

  logic signed [DW-1:0]   s2_v0 [3];
  logic signed [DW-1:0]   s2_v1 [3];
  logic signed [DW-1:0]   s2_v2 [3];
  logic signed [PW-1:0]   s3_p  [5][3];
  logic signed [DOTW-1:0] s4_d  [5];
  logic signed [WW-1:0]   m     [6];
  logic signed [WW:0]     s7_den, s7_un, s7_vn;
  logic signed [WW+2:0]   rest;

  // token pipeline, matches the datapath depth
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tok <= '0;
      s3_tok <= '0;
      s4_tok <= '0;
      s5_tok <= '0;
      s6_tok <= '0;
      s7_tok <= '0;
      s8_tok <= '0;
    end else begin
      s2_tok <= tok_in;
      s3_tok <= s2_tok;
      s4_tok <= s3_tok;
      s5_tok <= s4_tok;
      s6_tok <= s5_tok;
      s7_tok <= s6_tok;
      s8_tok <= s7_tok;
    end
  end

  // edge vectors c-a, b-a, p-a
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_v0[i] <= DW'(signed'(c_in[i*C +: C])) - DW'(signed'(a_in[i*C +: C]));
      s2_v1[i] <= DW'(signed'(b_in[i*C +: C])) - DW'(signed'(a_in[i*C +: C]));
      s2_v2[i] <= DW'(signed'(p_in[i*C +: C])) - DW'(signed'(a_in[i*C +: C]));
    end
  end

  // per-axis products of the five dot products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_p[0][i] <= s2_v0[i] * s2_v0[i];
      s3_p[1][i] <= s2_v0[i] * s2_v1[i];
      s3_p[2][i] <= s2_v0[i] * s2_v2[i];
      s3_p[3][i] <= s2_v1[i] * s2_v1[i];
      s3_p[4][i] <= s2_v1[i] * s2_v2[i];
    end
  end

  // dot sums: d00 d01 d02 d11 d12
  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      s4_d[k] <= DOTW'(s3_p[k][0]) + DOTW'(s3_p[k][1]) + DOTW'(s3_p[k][2]);
    end
  end

  // second-level products
  pit_wmul #(.W(DOTW)) u_mul0 (.clk(clk), .a(s4_d[0]), .b(s4_d[3]), .p(m[0]));
  pit_wmul #(.W(DOTW)) u_mul1 (.clk(clk), .a(s4_d[1]), .b(s4_d[1]), .p(m[1]));
  pit_wmul #(.W(DOTW)) u_mul2 (.clk(clk), .a(s4_d[3]), .b(s4_d[2]), .p(m[2]));
  pit_wmul #(.W(DOTW)) u_mul3 (.clk(clk), .a(s4_d[1]), .b(s4_d[4]), .p(m[3]));
  pit_wmul #(.W(DOTW)) u_mul4 (.clk(clk), .a(s4_d[0]), .b(s4_d[4]), .p(m[4]));
  pit_wmul #(.W(DOTW)) u_mul5 (.clk(clk), .a(s4_d[1]), .b(s4_d[2]), .p(m[5]));

  // denominator and the two numerators
  always_ff @(posedge clk) begin
    s7_den <= (WW+1)'(m[0]) - (WW+1)'(m[1]);
    s7_un  <= (WW+1)'(m[2]) - (WW+1)'(m[3]);
    s7_vn  <= (WW+1)'(m[4]) - (WW+1)'(m[5]);
  end

  // final decision
  assign rest = (WW+3)'(s7_den) - (WW+3)'(s7_un) - (WW+3)'(s7_vn);

  always_ff @(posedge clk) begin
    hit <= (s7_den > 0) && !s7_un[WW] && !s7_vn[WW] && (rest > 0);
  end

  assign tok_out = s8_tok;

endmodule

// ----- design/point_in_triangle_mesh_test.sv -----
// ----------------------------------------------------------------------------
// point_in_triangle_mesh_test
// tests a point against a stored table of triangles
// ----------------------------------------------------------------------------
// usage:
//   command channel: an item transfers when start is high and busy is low.
//   action = load writes one corner (coord_x/y/z) of triangle slot, and busy
//   stays low. action = query tests the point against the first
//   triangle_count slots (capped at MAX_TRIANGLES).
//   result: done pulses for one cycle with inside_res; one per query only.
//   a query issues one triangle per cycle into the test pipeline and keeps
//   busy high until its last triangle leaves the pipeline.
//   the next item may transfer in the cycle that done is high.
//   config: cfg_we writes cfg_data into triangle_count; the user must do so
//   only while idle, and the block itself does not enforce this.
//   reset: triangle_count clears to zero and the block goes idle; the corner
//   memory keeps whatever it holds and must be loaded before it is tested.
//   the receiver cannot stall: done is never held off.
// ----------------------------------------------------------------------------
module point_in_triangle_mesh_test import pit_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [7:0]                   slot,
  input  logic [1:0]                   corner,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic                         cfg_we,
  input  logic [CFG_W-1:0]             cfg_data,
  output logic                         done,
  output logic                         inside_res
);

  localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int NW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam int EW = 3 * COORD_BITS;

  logic [CFG_W-1:0] triangle_count;
  state_t           state, state_next;
  logic [IW-1:0]    idx;
  logic [NW-1:0]    n_q, n_eff;
  logic [EW-1:0]    pt, wdata;
  logic [IW+7:0]    slot_ext;
  logic             acc;
  logic             accept, ld_ok, we_a, we_b, we_c;
  tok_t             issue_tok, tok1, tok_out;
  logic [EW-1:0]    rd_a, rd_b, rd_c;
  logic             hit, hit_now;

  // command transfer decode
  assign accept   = start && !busy;
  assign slot_ext = (IW+8)'(slot);
  assign ld_ok    = accept && (action == ACT_LOAD) && (slot_ext < (IW+8)'(MAX_TRIANGLES));
  assign we_a     = ld_ok && (corner == CORNER_A);
  assign we_b     = ld_ok && (corner == CORNER_B);
  assign we_c     = ld_ok && (corner == CORNER_C);
  assign wdata    = {coord_z, coord_y, coord_x};

  // effective triangle count
  always_comb begin
    n_eff = NW'(triangle_count);
    if (n_eff > NW'(MAX_TRIANGLES)) begin
      n_eff = NW'(MAX_TRIANGLES);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_count <= '0;
    end else if (cfg_we) begin
      triangle_count <= cfg_data;
    end
  end

  // sequencer outputs
  always_comb begin
    busy           = (state != ST_IDLE);
    issue_tok.vld  = (state == ST_ISSUE) && (n_q != '0);
    issue_tok.last = (state == ST_ISSUE) &&
                     ((n_q == '0) || (NW'(idx) + NW'(1) == n_q));
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_QUERY)) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_tok.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tok_out.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      tok1  <= '0;
    end else begin
      state <= state_next;
      tok1  <= issue_tok;
      if (state == ST_IDLE) begin
        idx <= '0;
      end else if (state == ST_ISSUE) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // query payload
  always_ff @(posedge clk) begin
    if (accept && (action == ACT_QUERY)) begin
      n_q <= n_eff;
      pt  <= {coord_z, coord_y, coord_x};
    end
  end

  // one corner memory per triangle corner
  pit_ram #(.WIDTH(EW), .DEPTH(MAX_TRIANGLES), .AW(IW)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(slot_ext[IW-1:0]), .wdata(wdata),
    .raddr(idx), .rdata(rd_a)
  );
  pit_ram #(.WIDTH(EW), .DEPTH(MAX_TRIANGLES), .AW(IW)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(slot_ext[IW-1:0]), .wdata(wdata),
    .raddr(idx), .rdata(rd_b)
  );
  pit_ram #(.WIDTH(EW), .DEPTH(MAX_TRIANGLES), .AW(IW)) u_ram_c (
    .clk(clk), .we(we_c), .waddr(slot_ext[IW-1:0]), .wdata(wdata),
    .raddr(idx), .rdata(rd_c)
  );

  // test pipeline
  pit_tri_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk(clk), .rst(rst), .tok_in(tok1),
    .a_in(rd_a), .b_in(rd_b), .c_in(rd_c), .p_in(pt),
    .tok_out(tok_out), .hit(hit)
  );

  // hit accumulation and result transfer
  assign hit_now = tok_out.vld && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= 1'b0;
      done <= 1'b0;
    end else if (tok_out.last) begin
      acc  <= 1'b0;
      done <= 1'b1;
    end else begin
      acc  <= acc || hit_now;
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_out.last) begin
      inside_res <= acc || hit_now;
    end
  end

endmodule

// ----- design/pit_checker.sv -----
// ----------------------------------------------------------------------------
// pit_checker
// port-level checks of the point-in-triangle mesh test
// ----------------------------------------------------------------------------
`include "point_in_triangle_mesh_test_defines.svh"

module pit_checker import pit_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic done
);

  // a query keeps the block busy
  `PIT_ASSERT_NEXT(a_query_busy, start && !busy && (action == ACT_QUERY), busy)
  // a load finishes in its own cycle
  `PIT_ASSERT_NEXT(a_load_idle, start && !busy && (action == ACT_LOAD), !busy)
  // a result comes only once the block is free again
  `PIT_ASSERT_NOW(a_done_idle, done, !busy)
  // one result per query
  `PIT_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind point_in_triangle_mesh_test pit_checker u_pit_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .done(done)
);

// ----- tb/point_in_triangle_mesh_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_mesh_test_tb
// loads random and hand-made triangles, then queries points against them;
// a scoreboard predicts each inside answer with exact barycentric math and
// compares it with the block's done/inside_res output
// ----------------------------------------------------------------------------
module point_in_triangle_mesh_test_tb;
  import pit_pkg::*;

  localparam int NTRI = 256;
  localparam int CB = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = ACT_LOAD;
  logic [7:0] slot = '0;
  logic [1:0] corner = CORNER_A;
  logic signed [CB-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done, inside_res;

  point_in_triangle_mesh_test dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .slot(slot), .corner(corner), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .inside_res(inside_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicts inside answers from its own copy of the triangle table
  class hit_scoreboard;
    logic signed [CB-1:0] cx[NTRI*3], cy[NTRI*3], cz[NTRI*3];
    bit written[NTRI*3];
    int unsigned tri_limit;
    bit hits_pending[$];
    int errors;

    function new();
      tri_limit = 0;
      errors = 0;
    endfunction

    function bit tri_hit(int t, logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                         logic signed [CB-1:0] pz);
      longint v0[3], v1[3], v2[3];
      longint d00, d01, d02, d11, d12;
      logic signed [127:0] den, un, vn;
      v0[0] = cx[t*3+2] - cx[t*3]; v0[1] = cy[t*3+2] - cy[t*3];
      v0[2] = cz[t*3+2] - cz[t*3];
      v1[0] = cx[t*3+1] - cx[t*3]; v1[1] = cy[t*3+1] - cy[t*3];
      v1[2] = cz[t*3+1] - cz[t*3];
      v2[0] = px - cx[t*3]; v2[1] = py - cy[t*3]; v2[2] = pz - cz[t*3];
      d00 = v0[0]*v0[0] + v0[1]*v0[1] + v0[2]*v0[2];
      d01 = v0[0]*v1[0] + v0[1]*v1[1] + v0[2]*v1[2];
      d02 = v0[0]*v2[0] + v0[1]*v2[1] + v0[2]*v2[2];
      d11 = v1[0]*v1[0] + v1[1]*v1[1] + v1[2]*v1[2];
      d12 = v1[0]*v2[0] + v1[1]*v2[1] + v1[2]*v2[2];
      den = 128'(signed'(d00)) * 128'(signed'(d11)) - 128'(signed'(d01)) * 128'(signed'(d01));
      un = 128'(signed'(d11)) * 128'(signed'(d02)) - 128'(signed'(d01)) * 128'(signed'(d12));
      vn = 128'(signed'(d00)) * 128'(signed'(d12)) - 128'(signed'(d01)) * 128'(signed'(d02));
      return den > 0 && un >= 0 && vn >= 0 && un + vn < den;
    endfunction

    function void note_transfer(logic act, logic [7:0] s, logic [1:0] c,
                                logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                logic signed [CB-1:0] z);
      int n;
      bit hit;
      if (act == ACT_LOAD) begin
        if (s < NTRI && c != 2'd3) begin
          cx[s*3+c] = x; cy[s*3+c] = y; cz[s*3+c] = z;
          written[s*3+c] = 1'b1;
        end
        return;
      end
      n = tri_limit > NTRI ? NTRI : tri_limit;
      hit = 1'b0;
      for (int t = 0; t < n && !hit; t++)
        hit = tri_hit(t, x, y, z);
      hits_pending = {hits_pending, hit};
    endfunction

    function void check_result(logic got);
      if (hits_pending.size() == 0) begin
        if (errors < 10) $display("unexpected result inside_res=%0d", got);
        errors++;
      end else begin
        logic want = hits_pending.pop_front();
        if (want !== got) begin
          if (errors < 10) $display("inside_res mismatch: expected %0d actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  hit_scoreboard sb = new();
  int unsigned cycles = 0;

  // result monitor and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(inside_res);
    if (cycles > CYCLE_LIMIT) begin
      $display("point_in_triangle_mesh_test test failed");
      $finish;
    end
  end

  // random idle time with start low
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one command transfer; returns at the falling edge after acceptance with
  // start still high, so the next call can follow back to back
  task automatic send(logic act, logic [7:0] s, logic [1:0] c, logic signed [CB-1:0] x,
                      logic signed [CB-1:0] y, logic signed [CB-1:0] z);
    action <= act; slot <= s; corner <= c;
    coord_x <= x; coord_y <= y; coord_z <= z;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(act, s, c, x, y, z);
    @(negedge clk);
  endtask

  task automatic load_tri(int t, logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
                          logic signed [CB-1:0] bx, logic signed [CB-1:0] by,
                          logic signed [CB-1:0] qx, logic signed [CB-1:0] qy,
                          logic signed [CB-1:0] z);
    send(ACT_LOAD, 8'(t), CORNER_A, ax, ay, z);
    send(ACT_LOAD, 8'(t), CORNER_B, bx, by, z);
    send(ACT_LOAD, 8'(t), CORNER_C, qx, qy, z);
  endtask

  // wait out all pending answers, then the pipeline tail
  task automatic drain();
    start <= 1'b0;
    while (sb.hits_pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_count(int unsigned n);
    start <= 1'b0;
    cfg_data <= CFG_W'(n);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.tri_limit = n;
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(bit wide);
    if (wide) return CB'($urandom());
    return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every slot gets all three corners so no query reads unwritten data
    for (int t = 0; t < NTRI; t++)
      load_tri(t, rnd_coord(t < 8), rnd_coord(t < 8), rnd_coord(t < 8),
               rnd_coord(t < 8), rnd_coord(t < 8), rnd_coord(t < 8), rnd_coord(t < 8));

    // directed: slot 0 right triangle (0,0)(256,0)(0,256), z = 0
    load_tri(0, '0, '0, 16'sd256, '0, '0, 16'sd256, '0);
    load_tri(1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd7);  // degenerate
    send(ACT_LOAD, 8'd2, 2'd3, 16'sh7fff, 16'sh7fff, 16'sh7fff);   // ignored corner
    set_count(0);
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd10, 16'sd10, '0);  // count zero
    drain();
    set_count(2);
    send(ACT_QUERY, 8'hff, 2'd3, 16'sd10, 16'sd10, '0);        // inside
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd100, '0, '0);         // on edge a-b
    send(ACT_QUERY, 8'd0, CORNER_A, '0, 16'sd100, '0);         // on edge a-c
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd128, 16'sd128, '0);   // on edge b-c
    send(ACT_QUERY, 8'd0, CORNER_A, '0, '0, '0);               // corner a
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd200, 16'sd200, '0);   // outside
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd5, 16'sd5, 16'sd5);   // degenerate point
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sh8000, 16'sh7fff, 16'sh8000);
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sh7fff, 16'sh8000, 16'sh7fff);
    drain();
    set_count(511);  // above the table size: all slots
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sd1, 16'sd1, '0);
    send(ACT_QUERY, 8'd0, CORNER_A, 16'sh8000, 16'sh8000, 16'sh8000);
    drain();

    // random phases: mostly small counts, a few large ones (the last one full-table)
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned cnt;
      cnt = (ph % 4 == 3) ? (ph == 11 ? 256 : $urandom_range(200, 511))
                          : $urandom_range(1, 12);
      set_count(cnt);
      for (int i = 0; i < 75; i++) begin
        int unsigned t;
        idle_gap();
        t = $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) begin
          // corner load, sometimes to a small-coordinate triangle
          send(ACT_LOAD, 8'(t), 2'($urandom_range(0, 3)),
               rnd_coord($urandom_range(0, 4) == 0),
               rnd_coord($urandom_range(0, 4) == 0), rnd_coord($urandom_range(0, 4) == 0));
        end else if ($urandom_range(0, 1) == 0 && t < 3) begin
          // point near triangle t: a + s*(b-a) + r*(c-a) with random weights
          int r1, r2;
          r1 = $urandom_range(0, 256); r2 = $urandom_range(0, 256);
          send(ACT_QUERY, 8'($urandom()), 2'($urandom()),
               CB'(sb.cx[t*3] + ((sb.cx[t*3+1]-sb.cx[t*3])*r1
                                 + (sb.cx[t*3+2]-sb.cx[t*3])*r2) / 256),
               CB'(sb.cy[t*3] + ((sb.cy[t*3+1]-sb.cy[t*3])*r1
                                 + (sb.cy[t*3+2]-sb.cy[t*3])*r2) / 256),
               CB'(sb.cz[t*3] + ((sb.cz[t*3+1]-sb.cz[t*3])*r1
                                 + (sb.cz[t*3+2]-sb.cz[t*3])*r2) / 256));
        end else begin
          send(ACT_QUERY, 8'($urandom()), 2'($urandom()),
               rnd_coord($urandom_range(0, 3) == 0),
               rnd_coord($urandom_range(0, 3) == 0), rnd_coord($urandom_range(0, 3) == 0));
        end
      end
      // reload slot 0 as a flat triangle so hits stay common
      load_tri(0, rnd_coord(1'b0), rnd_coord(1'b0), 16'sd900, rnd_coord(1'b0),
               rnd_coord(1'b0), 16'sd900, '0);
      drain();
    end

    if (sb.errors == 0 && sb.hits_pending.size() == 0) begin
      $display("point_in_triangle_mesh_test test passed");
    end else begin
      $display("point_in_triangle_mesh_test test failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/pit_pkg.sv
design/pit_ram.sv
design/pit_wmul.sv
design/pit_tri_test.sv
design/point_in_triangle_mesh_test.sv
design/pit_checker.sv
tb/point_in_triangle_mesh_test_tb.sv
